@@ hw/rtl/gif_lzw_encoder_macros.svh @@
// Assertion macros shared by the GIF LZW encoder RTL.
// Each macro expects signals named clk and rst in the including module.
`ifndef GIF_LZW_ENCODER_MACROS_SVH
`define GIF_LZW_ENCODER_MACROS_SVH

// Implication checked in the same cycle.
`define GLE_ASSERT_IMP(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) \
    else $error(msg);

// Implication checked in the following cycle.
`define GLE_ASSERT_NXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error(msg);

`endif

@@ hw/rtl/gle_pkg.sv @@
// Shared types and constants of the GIF LZW encoder.
// No dependencies; used by gle_packer and gif_lzw_encoder.
`timescale 1ns / 1ps

package gle_pkg;

  // String table geometry.
  localparam int TABLE_SIZE    = 5003;
  localparam int IDX_W         = $clog2(TABLE_SIZE);
  localparam int MAX_CODE_BITS = 12;
  localparam int CODE_W        = MAX_CODE_BITS;
  localparam int CODE_SPACE    = 1 << MAX_CODE_BITS;
  localparam int HASH_SHIFT    = MAX_CODE_BITS - 8;
  localparam int PIX_W         = 8;
  localparam int KEY_W         = PIX_W + CODE_W;
  localparam int ENTRY_W       = KEY_W + CODE_W;

  // Code counters and widths.
  localparam int NFC_W      = MAX_CODE_BITS + 1;
  localparam int WIDTH_W    = 4;
  localparam int ROOT_W     = 4;
  localparam int ROOT_MIN   = 2;
  localparam int ROOT_MAX   = 8;
  localparam int ROOT_RESET = 8;

  // Bit packer and byte backlog.
  localparam int ACC_W       = 24;
  localparam int PEND_W      = 3;
  localparam int QUEUE_DEPTH = 16;
  localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = Q_IDX_W + 1;
  localparam int MAX_OUT     = 4;
  localparam int EMIT_W      = 3;

  // One input word: a palette index and the end-of-image mark.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             end_of_image;
  } pixel_word_t;

  // One output word: a code stream byte and its marks.
  typedef struct packed {
    logic [7:0] code_byte;
    logic       run_last;
    logic       stream_done;
  } byte_word_t;

  // Commands from the sequencer to the bit packer.
  typedef struct packed {
    logic               put;
    logic               flush;
    logic               arm;
    logic [CODE_W-1:0]  code;
    logic [WIDTH_W-1:0] width;
  } pk_cmd_t;

endpackage

@@ hw/rtl/gle_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module gle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/gle_packer.sv @@
// Bit packer, byte backlog and output register of the GIF LZW encoder.
// Depends on gle_pkg and gif_lzw_encoder_macros.svh.
`timescale 1ns / 1ps
`include "gif_lzw_encoder_macros.svh"

module gle_packer (
  input  logic                clk,
  input  logic                rst,
  input  gle_pkg::pk_cmd_t    cmd,
  output logic                drained,
  output logic                byte_valid,
  input  logic                byte_stall,
  output gle_pkg::byte_word_t byte_data
);

  logic [gle_pkg::ACC_W-1:0]   acc;
  logic [gle_pkg::PEND_W-1:0]  pending;
  logic [7:0]                  q_byte [gle_pkg::QUEUE_DEPTH];
  logic [gle_pkg::QUEUE_DEPTH-1:0] q_done;
  logic [gle_pkg::Q_IDX_W-1:0] head;
  logic [gle_pkg::Q_CNT_W-1:0] count;
  logic [gle_pkg::Q_IDX_W-1:0] last;
  logic [gle_pkg::EMIT_W-1:0]  emit_left;

  logic [gle_pkg::ACC_W-1:0]   acc_put;
  logic [gle_pkg::ACC_W-1:0]   acc_shift;
  logic [4:0]                  bits_put;
  logic [gle_pkg::Q_IDX_W-1:0] tail;
  logic [gle_pkg::Q_IDX_W-1:0] tail_inc;
  logic                        wr0;
  logic                        wr1;
  logic [7:0]                  byte0;
  logic [gle_pkg::Q_CNT_W-1:0] count_push;
  logic [gle_pkg::Q_CNT_W-1:0] count_next;
  logic [gle_pkg::Q_IDX_W-1:0] last_next;
  logic [gle_pkg::EMIT_W-1:0]  emit_min;
  logic                        load;

  // Merge the code above the pending bits and work out how many bytes complete.
  always_comb begin
    acc_put  = acc | (gle_pkg::ACC_W'(cmd.code) << pending);
    bits_put = 5'(pending) + 5'(cmd.width);
    if (bits_put >= 5'd16) begin
      acc_shift = acc_put >> 16;
    end else if (bits_put >= 5'd8) begin
      acc_shift = acc_put >> 8;
    end else begin
      acc_shift = acc_put;
    end
  end

  // Backlog writes: up to two bytes per code, one on a flush; a full backlog drops.
  always_comb begin
    tail     = head + count[gle_pkg::Q_IDX_W-1:0];
    tail_inc = tail + gle_pkg::Q_IDX_W'(1);
    wr0 = ((cmd.put && bits_put >= 5'd8) || (cmd.flush && pending != '0)) &&
          (count != gle_pkg::Q_CNT_W'(gle_pkg::QUEUE_DEPTH));
    wr1 = cmd.put && bits_put >= 5'd16 &&
          (count < gle_pkg::Q_CNT_W'(gle_pkg::QUEUE_DEPTH - 1));
    byte0      = cmd.flush ? acc[7:0] : acc_put[7:0];
    count_push = count + gle_pkg::Q_CNT_W'(wr0) + gle_pkg::Q_CNT_W'(wr1);
    if (wr1) begin
      last_next = tail_inc;
    end else if (wr0) begin
      last_next = tail;
    end else begin
      last_next = last;
    end
  end

  // Emission: at most four words per input word, taken from the backlog head.
  always_comb begin
    load       = (emit_left != '0) && (!byte_valid || !byte_stall);
    count_next = count_push - gle_pkg::Q_CNT_W'(load);
    if (count_next > gle_pkg::Q_CNT_W'(gle_pkg::MAX_OUT)) begin
      emit_min = gle_pkg::EMIT_W'(gle_pkg::MAX_OUT);
    end else begin
      emit_min = count_next[gle_pkg::EMIT_W-1:0];
    end
    drained = (emit_left == '0) ||
              (emit_left == gle_pkg::EMIT_W'(1) && load);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      pending    <= '0;
      head       <= '0;
      count      <= '0;
      last       <= '0;
      emit_left  <= '0;
      byte_valid <= 1'b0;
    end else begin
      if (cmd.put) begin
        acc     <= acc_shift;
        pending <= bits_put[gle_pkg::PEND_W-1:0];
      end else if (cmd.flush) begin
        acc     <= '0;
        pending <= '0;
      end
      head  <= head + gle_pkg::Q_IDX_W'(load);
      count <= count_next;
      last  <= last_next;
      if (cmd.arm) begin
        emit_left <= emit_min;
      end else if (load) begin
        emit_left <= emit_left - gle_pkg::EMIT_W'(1);
      end
      if (load) begin
        byte_valid <= 1'b1;
      end else if (!byte_stall) begin
        byte_valid <= 1'b0;
      end
    end
  end

  // Backlog storage and output word.
  always_ff @(posedge clk) begin
    // The final byte of an image carries the stream end mark.
    if (wr0) begin
      q_byte[tail] <= byte0;
      q_done[tail] <= cmd.flush;
    end
    if (wr1) begin
      q_byte[tail_inc] <= acc_put[15:8];
      q_done[tail_inc] <= 1'b0;
    end
    // A flush that adds no byte marks the newest byte already waiting.
    if (cmd.flush && !wr0 && count != '0) begin
      q_done[last] <= 1'b1;
    end
    if (load) begin
      byte_data.code_byte   <= q_byte[head];
      byte_data.run_last    <= (emit_left == gle_pkg::EMIT_W'(1));
      byte_data.stream_done <= q_done[head];
    end
  end

  `GLE_ASSERT_IMP(a_count_bound, 1'b1, count <= gle_pkg::Q_CNT_W'(gle_pkg::QUEUE_DEPTH), "backlog count overflow")
  `GLE_ASSERT_IMP(a_emit_covered, emit_left != '0, count >= gle_pkg::Q_CNT_W'(emit_left), "emission beyond backlog")
  `GLE_ASSERT_IMP(a_cmd_excl, cmd.put, !cmd.flush, "code put and flush together")

endmodule

@@ hw/rtl/gif_lzw_encoder.sv @@
// GIF LZW encoder: one pixel word in, packed code bytes out, LSB first.
// Each word is looked up in the string table, with one more probe per hash collision; a miss, a
// table-full restart and end of image add states, and the word is held until its bytes are out.
// A new pixel word is taken only once the last one is done; the string table has one read port.
// A table clear sweeps all 5003 entries (no pixel taken) after the first
// pixel of an image and after each table-full restart. Reset is synchronous; root_cfg = 8.
`timescale 1ns / 1ps
`include "gif_lzw_encoder_macros.svh"

module gif_lzw_encoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [gle_pkg::ROOT_W-1:0]   cfg_wdata,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  input  gle_pkg::pixel_word_t         pixel_data,
  output logic                         byte_valid,
  input  logic                         byte_stall,
  output gle_pkg::byte_word_t          byte_data
);

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_START      = 4'd1;
  localparam logic [3:0] S_PROBE      = 4'd2;
  localparam logic [3:0] S_MISS       = 4'd3;
  localparam logic [3:0] S_FULL       = 4'd4;
  localparam logic [3:0] S_EOI_PREFIX = 4'd5;
  localparam logic [3:0] S_EOI_END    = 4'd6;
  localparam logic [3:0] S_FLUSH      = 4'd7;
  localparam logic [3:0] S_EMIT       = 4'd8;
  localparam logic [3:0] S_CLEAR      = 4'd9;

  // Clamp the configured root width to the legal range.
  function automatic logic [gle_pkg::ROOT_W-1:0] clamp_root(
    input logic [gle_pkg::ROOT_W-1:0] r
  );
    logic [gle_pkg::ROOT_W-1:0] res;
    if (r < gle_pkg::ROOT_W'(gle_pkg::ROOT_MIN)) begin
      res = gle_pkg::ROOT_W'(gle_pkg::ROOT_MIN);
    end else if (r > gle_pkg::ROOT_W'(gle_pkg::ROOT_MAX)) begin
      res = gle_pkg::ROOT_W'(gle_pkg::ROOT_MAX);
    end else begin
      res = r;
    end
    return res;
  endfunction

  // Mask of the pixel bits below the root width.
  function automatic logic [gle_pkg::PIX_W-1:0] root_mask(
    input logic [gle_pkg::ROOT_W-1:0] r
  );
    logic [gle_pkg::PIX_W:0] ones;
    ones = ((gle_pkg::PIX_W+1)'(1) << r) - (gle_pkg::PIX_W+1)'(1);
    return ones[gle_pkg::PIX_W-1:0];
  endfunction

  logic [3:0]                          state;
  logic [3:0]                          state_next;
  logic [gle_pkg::ROOT_W-1:0]          root_cfg;
  logic [gle_pkg::ROOT_W-1:0]          root;
  logic                                started;
  logic                                need_clear;
  logic [gle_pkg::CODE_W-1:0]          prefix;
  logic [gle_pkg::NFC_W-1:0]           nfc;
  logic [gle_pkg::NFC_W-1:0]           limit;
  logic [gle_pkg::WIDTH_W-1:0]         width;
  logic [gle_pkg::PIX_W-1:0]           pix;
  logic                                eoi;
  logic [gle_pkg::IDX_W-1:0]           idx;
  logic [gle_pkg::IDX_W-1:0]           probes;
  logic                                slot;
  logic [gle_pkg::IDX_W-1:0]           clr;

  logic                                accept;
  logic [gle_pkg::ROOT_W-1:0]          root_new;
  logic [gle_pkg::CODE_W-1:0]          clear_new;
  logic [gle_pkg::CODE_W-1:0]          clear_code;
  logic [gle_pkg::PIX_W-1:0]           pix_in_m;
  logic [gle_pkg::PIX_W-1:0]           pix_m;
  logic [gle_pkg::IDX_W-1:0]           hash_sum;
  logic [gle_pkg::IDX_W-1:0]           hash_idx;
  logic [gle_pkg::KEY_W-1:0]           key;
  logic [gle_pkg::IDX_W-1:0]           stride;
  logic [gle_pkg::IDX_W-1:0]           stride_new;
  logic [gle_pkg::IDX_W-1:0]           next_idx;
  logic [gle_pkg::CODE_W-1:0]          ent_code;
  logic [gle_pkg::KEY_W-1:0]           ent_key;
  logic                                probe_empty;
  logic                                probe_hit;
  logic                                probe_last;
  logic                                room;
  logic [gle_pkg::WIDTH_W-1:0]         width_wide;
  logic [gle_pkg::NFC_W-1:0]           limit_wide;

  logic                                ram_we;
  logic [gle_pkg::IDX_W-1:0]           ram_waddr;
  logic [gle_pkg::ENTRY_W-1:0]         ram_wdata;
  logic                                ram_re;
  logic [gle_pkg::IDX_W-1:0]           ram_raddr;
  logic [gle_pkg::ENTRY_W-1:0]         ram_rdata;

  gle_pkg::pk_cmd_t                    pk_cmd;
  logic                                pk_drained;

  assign pixel_stall = (state != S_IDLE);
  assign accept      = pixel_valid && !pixel_stall;

  // Codes, hash index and probe step; the step stays fixed for the whole probe sequence.
  always_comb begin
    root_new   = clamp_root(root_cfg);
    clear_new  = gle_pkg::CODE_W'(1) << root_new;
    clear_code = gle_pkg::CODE_W'(1) << root;
    pix_in_m   = pixel_data.pixel & root_mask(root);
    pix_m      = pix & root_mask(root);
    hash_sum   = gle_pkg::IDX_W'(gle_pkg::CODE_W'(pix_in_m) << gle_pkg::HASH_SHIFT) +
                 gle_pkg::IDX_W'(prefix);
    if (hash_sum >= gle_pkg::IDX_W'(gle_pkg::TABLE_SIZE)) begin
      hash_idx = hash_sum - gle_pkg::IDX_W'(gle_pkg::TABLE_SIZE);
    end else begin
      hash_idx = hash_sum;
    end
    key        = {pix_m, prefix};
    stride_new = (hash_idx != '0) ? gle_pkg::IDX_W'(gle_pkg::TABLE_SIZE) - hash_idx
                                  : gle_pkg::IDX_W'(1);
    if (idx >= stride) begin
      next_idx = idx - stride;
    end else begin
      next_idx = gle_pkg::IDX_W'(gle_pkg::TABLE_SIZE) - stride + idx;
    end
    ent_code    = ram_rdata[gle_pkg::CODE_W-1:0];
    ent_key     = ram_rdata[gle_pkg::ENTRY_W-1:gle_pkg::CODE_W];
    probe_empty = (ent_code == '0);
    probe_hit   = !probe_empty && (ent_key == key);
    probe_last  = (probes == gle_pkg::IDX_W'(gle_pkg::TABLE_SIZE - 1));
    room        = (nfc < gle_pkg::NFC_W'(gle_pkg::CODE_SPACE));
  end

  // Code width growth once the next free code passes the limit.
  always_comb begin
    width_wide = width;
    limit_wide = limit;
    if (nfc > limit) begin
      width_wide = width + gle_pkg::WIDTH_W'(1);
      if (width_wide < gle_pkg::WIDTH_W'(gle_pkg::MAX_CODE_BITS)) begin
        limit_wide = {limit[gle_pkg::NFC_W-2:0], 1'b1};
      end else begin
        limit_wide = gle_pkg::NFC_W'(gle_pkg::CODE_SPACE);
      end
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = started ? S_PROBE : S_START;
        end
      end
      S_START: begin
        state_next = eoi ? S_EOI_PREFIX : S_EMIT;
      end
      S_PROBE: begin
        priority if (probe_empty) begin
          state_next = S_MISS;
        end else if (probe_hit) begin
          state_next = eoi ? S_EOI_PREFIX : S_EMIT;
        end else if (probe_last) begin
          state_next = S_MISS;
        end else begin
          state_next = S_PROBE;
        end
      end
      S_MISS: begin
        if (room) begin
          state_next = eoi ? S_EOI_PREFIX : S_EMIT;
        end else begin
          state_next = S_FULL;
        end
      end
      S_FULL: begin
        state_next = eoi ? S_EOI_PREFIX : S_EMIT;
      end
      S_EOI_PREFIX: begin
        state_next = S_EOI_END;
      end
      S_EOI_END: begin
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (pk_drained) begin
          state_next = need_clear ? S_CLEAR : S_IDLE;
        end
      end
      S_CLEAR: begin
        if (clr == gle_pkg::IDX_W'(gle_pkg::TABLE_SIZE - 1)) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Table accesses and packer commands.
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = idx;
    ram_wdata    = {key, nfc[gle_pkg::CODE_W-1:0]};
    ram_re       = 1'b0;
    ram_raddr    = hash_idx;
    pk_cmd.put   = 1'b0;
    pk_cmd.flush = 1'b0;
    pk_cmd.arm   = (state_next == S_EMIT) && (state != S_EMIT);
    pk_cmd.code  = prefix;
    pk_cmd.width = width;
    unique case (state)
      S_IDLE: begin
        ram_re = accept;
      end
      S_START: begin
        pk_cmd.put   = 1'b1;
        pk_cmd.code  = clear_new;
        pk_cmd.width = gle_pkg::WIDTH_W'(root_new) + gle_pkg::WIDTH_W'(1);
      end
      S_PROBE: begin
        ram_re    = !probe_empty && !probe_hit && !probe_last;
        ram_raddr = next_idx;
      end
      S_MISS: begin
        ram_we     = room && slot;
        pk_cmd.put = 1'b1;
      end
      S_FULL: begin
        pk_cmd.put  = 1'b1;
        pk_cmd.code = clear_code;
      end
      S_EOI_PREFIX: begin
        pk_cmd.put = 1'b1;
      end
      S_EOI_END: begin
        pk_cmd.put  = 1'b1;
        pk_cmd.code = clear_code + gle_pkg::CODE_W'(1);
      end
      S_FLUSH: begin
        pk_cmd.flush = 1'b1;
      end
      S_EMIT: begin
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = '0;
      end
      default: begin
      end
    endcase
  end

  // Control and code state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      root_cfg   <= gle_pkg::ROOT_W'(gle_pkg::ROOT_RESET);
      root       <= '0;
      started    <= 1'b0;
      need_clear <= 1'b0;
      prefix     <= '0;
      nfc        <= '0;
      limit      <= '0;
      width      <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        root_cfg <= cfg_wdata;
      end
      unique case (state)
        S_START: begin
          root       <= root_new;
          nfc        <= gle_pkg::NFC_W'(clear_new) + gle_pkg::NFC_W'(2);
          limit      <= (gle_pkg::NFC_W'(clear_new) << 1) - gle_pkg::NFC_W'(1);
          width      <= gle_pkg::WIDTH_W'(root_new) + gle_pkg::WIDTH_W'(1);
          prefix     <= gle_pkg::CODE_W'(pix & root_mask(root_new));
          started    <= 1'b1;
          need_clear <= 1'b1;
        end
        S_PROBE: begin
          if (probe_hit) begin
            prefix <= ent_code;
          end
        end
        S_MISS: begin
          width  <= width_wide;
          limit  <= limit_wide;
          prefix <= gle_pkg::CODE_W'(pix_m);
          if (room && slot) begin
            nfc <= nfc + gle_pkg::NFC_W'(1);
          end
        end
        S_FULL: begin
          nfc        <= gle_pkg::NFC_W'(clear_code) + gle_pkg::NFC_W'(2);
          limit      <= (gle_pkg::NFC_W'(clear_code) << 1) - gle_pkg::NFC_W'(1);
          width      <= gle_pkg::WIDTH_W'(root) + gle_pkg::WIDTH_W'(1);
          need_clear <= 1'b1;
        end
        S_EOI_PREFIX: begin
          width <= width_wide;
          limit <= limit_wide;
        end
        S_FLUSH: begin
          started <= 1'b0;
        end
        S_CLEAR: begin
          if (clr == gle_pkg::IDX_W'(gle_pkg::TABLE_SIZE - 1)) begin
            need_clear <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Pixel word, probe position and step, and clear sweep counter.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          pix    <= pixel_data.pixel;
          eoi    <= pixel_data.end_of_image;
          idx    <= hash_idx;
          stride <= stride_new;
          probes <= '0;
        end
      end
      S_PROBE: begin
        slot <= probe_empty;
        if (ram_re) begin
          idx    <= next_idx;
          probes <= probes + gle_pkg::IDX_W'(1);
        end
      end
      S_EMIT: begin
        clr <= '0;
      end
      S_CLEAR: begin
        clr <= clr + gle_pkg::IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  // String table: key and code per entry, code zero marks an empty entry.
  gle_ram #(
    .WIDTH (gle_pkg::ENTRY_W),
    .DEPTH (gle_pkg::TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Code packing and byte output.
  gle_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .cmd        (pk_cmd),
    .drained    (pk_drained),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data)
  );

  `GLE_ASSERT_IMP(a_we_state, ram_we, (state == S_MISS) || (state == S_CLEAR), "table write outside miss or clear")
  `GLE_ASSERT_IMP(a_rw_excl, ram_we, !ram_re, "table read and write in one cycle")
  `GLE_ASSERT_NXT(a_accept_next, accept, (state == S_PROBE) || (state == S_START), "accepted word not processed")
  `GLE_ASSERT_IMP(a_width_max, started, width <= gle_pkg::WIDTH_W'(gle_pkg::MAX_CODE_BITS), "code width beyond limit")

endmodule

@@ test/tb_gif_lzw_encoder.sv @@
// Self-checking testbench for the GIF LZW encoder: predicts the packed code bytes per pixel word.
// Depends on gle_pkg for the word types and table constants, and on the gif_lzw_encoder RTL.
`timescale 1ns / 1ps

module tb_gif_lzw_encoder;
  import gle_pkg::*;

  // A full table sweep plus a long receiver stall still stays far below this.
  localparam int QUIET_LIMIT = 6 * TABLE_SIZE;

  typedef enum int {PROBE_EMPTY, PROBE_HIT, PROBE_FULL} probe_e;
  typedef enum int {MIX_ANY, MIX_FEW, MIX_RUNS} pixel_mix_e;

  // Predicts the byte stream of the encoder and holds the bytes still due.
  class lzw_byte_scoreboard;
    bit [CODE_W-1:0] slot_code [TABLE_SIZE];
    bit [KEY_W-1:0]  slot_key [TABLE_SIZE];
    int unsigned root_reg = ROOT_RESET;
    int unsigned root_used, prefix, next_code, code_limit, code_bits, acc, acc_bits;
    bit armed;
    byte_word_t held_bytes [$];
    byte_word_t due_bytes [$];
    int errors, pixels, images, restarts, bytes_seen;

    function void clear_table();
      foreach (slot_code[i]) slot_code[i] = '0;
    endfunction

    function void restart_codes();
      next_code  = (1 << root_used) + 2;
      code_limit = (2 << root_used) - 1;
      code_bits  = root_used + 1;
    endfunction

    function void widen();
      if (next_code > code_limit) begin
        code_bits++;
        code_limit = (code_bits < MAX_CODE_BITS) ? (code_limit << 1) + 1 : CODE_SPACE;
      end
    endfunction

    // Appends one code LSB first and moves every complete byte to the backlog.
    function void put_code(int unsigned code);
      byte_word_t b;
      acc |= (code & 'hFFF) << acc_bits;
      acc_bits += code_bits;
      while (acc_bits >= 8) begin
        b = '{code_byte: 8'(acc), run_last: 1'b0, stream_done: 1'b0};
        held_bytes.push_back(b);
        acc >>= 8;
        acc_bits -= 8;
      end
      acc &= 'hFFFFFF;
    endfunction

    // Walks the secondary probe sequence for the string prefix + pix.
    function probe_e probe(int unsigned pix, output int unsigned idx);
      int unsigned key, stride;
      key = (pix << MAX_CODE_BITS) | (prefix & 'hFFF);
      idx = ((pix << HASH_SHIFT) + (prefix & 'hFFF)) % TABLE_SIZE;
      stride = (idx != 0) ? TABLE_SIZE - idx : 1;
      for (int n = 0; n < TABLE_SIZE; n++) begin
        if (slot_code[idx] == 0) return PROBE_EMPTY;
        if (slot_key[idx] == key) return PROBE_HIT;
        idx = (idx >= stride) ? idx - stride : idx + TABLE_SIZE - stride;
      end
      return PROBE_FULL;
    endfunction

    // Advances the encoder state by one accepted pixel word and queues the bytes it releases.
    function void note_pixel(pixel_word_t w);
      int unsigned pix, idx;
      probe_e found;
      byte_word_t b;
      pixels++;
      if (!armed) begin
        root_used = (root_reg < ROOT_MIN) ? ROOT_MIN : (root_reg > ROOT_MAX) ? ROOT_MAX : root_reg;
        clear_table();
        restart_codes();
        put_code(1 << root_used);
        prefix = w.pixel & ((1 << root_used) - 1);
        armed = 1'b1;
      end else begin
        pix = w.pixel & ((1 << root_used) - 1);
        found = probe(pix, idx);
        if (found == PROBE_HIT) begin
          prefix = slot_code[idx];
        end else begin
          put_code(prefix);
          widen();
          if (next_code < CODE_SPACE) begin
            if (found == PROBE_EMPTY) begin
              slot_code[idx] = next_code;
              slot_key[idx] = (pix << MAX_CODE_BITS) | (prefix & 'hFFF);
              next_code++;
            end
          end else begin
            // Code space exhausted: start again with a clear code.
            clear_table();
            put_code(1 << root_used);
            restart_codes();
            restarts++;
          end
          prefix = pix;
        end
      end

      // End of image: last prefix, end code, then the partial byte.
      if (w.end_of_image) begin
        put_code(prefix);
        widen();
        put_code((1 << root_used) + 1);
        if (acc_bits != 0) begin
          b = '{code_byte: 8'(acc), run_last: 1'b0, stream_done: 1'b0};
          held_bytes.push_back(b);
        end
        acc = 0;
        acc_bits = 0;
        if (held_bytes.size() != 0) held_bytes[held_bytes.size() - 1].stream_done = 1'b1;
        armed = 1'b0;
        images++;
      end

      // At most four bytes leave per word; the rest wait for the next one.
      for (int n = 0; n < MAX_OUT && held_bytes.size() != 0; n++) begin
        b = held_bytes.pop_front();
        b.run_last = (n == MAX_OUT - 1) || (held_bytes.size() == 0);
        due_bytes.push_back(b);
      end
    endfunction

    function void check_byte(byte_word_t got);
      byte_word_t want;
      if (due_bytes.size() == 0) begin
        errors++;
        $display("%0t: byte word %h arrived with none expected", $time, got);
        return;
      end
      want = due_bytes.pop_front();
      bytes_seen++;
      if (got.code_byte !== want.code_byte) begin
        errors++;
        $display("%0t: code_byte expected %h, got %h", $time, want.code_byte, got.code_byte);
      end
      if (got.run_last !== want.run_last) begin
        errors++;
        $display("%0t: run_last expected %b, got %b", $time, want.run_last, got.run_last);
      end
      if (got.stream_done !== want.stream_done) begin
        errors++;
        $display("%0t: stream_done expected %b, got %b", $time, want.stream_done, got.stream_done);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [ROOT_W-1:0] cfg_wdata = '0;
  logic              pixel_valid = 1'b0;
  logic              pixel_stall;
  pixel_word_t       pixel_data = '0;
  logic              byte_valid;
  logic              byte_stall = 1'b0;
  byte_word_t        byte_data;

  int send_idle_pct = 27;
  int recv_idle_pct = 78;
  int quiet_cycles = 0;
  lzw_byte_scoreboard sb = new();

  gif_lzw_encoder uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_data (pixel_data),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver back-pressure, changed on the falling edge only.
  always @(negedge clk) begin
    byte_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Both handshakes are observed here, so the prediction always precedes the check.
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_valid && !pixel_stall) sb.note_pixel(pixel_data);
      if (byte_valid && !byte_stall) sb.check_byte(byte_data);
      if ((pixel_valid && !pixel_stall) || (byte_valid && !byte_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d bytes still due", $time,
                 quiet_cycles, sb.due_bytes.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Offers one pixel word and returns on the falling edge after it is taken.
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_data <= '{pixel: pix, end_of_image: last};
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds the sender until every due byte is out, then allows for a table sweep.
  task automatic settle();
    pixel_valid <= 1'b0;
    while (sb.due_bytes.size() != 0) @(negedge clk);
    repeat (TABLE_SIZE + 16) @(negedge clk);
  endtask

  task automatic write_root(input logic [ROOT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.root_reg = value;
  endtask

  // Random images of mostly short length, each ending with an end-of-image word.
  task automatic random_images(input int budget);
    int left, len;
    pixel_mix_e mix;
    logic [PIX_W-1:0] pix;
    left = budget;
    while (left > 0) begin
      len = ($urandom_range(0, 6) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
      if (len > left) len = left;
      mix = pixel_mix_e'($urandom_range(0, 2));
      for (int i = 0; i < len; i++) begin
        case (mix)
          MIX_ANY: pix = 8'($urandom_range(0, 255));
          MIX_FEW: pix = 8'($urandom_range(0, 2));
          default: pix = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'h00;
        endcase
        send_pixel(pix, i == len - 1);
      end
      left -= len;
    end
  endtask

  initial begin
    logic [ROOT_W-1:0] root_plan [9];
    logic [PIX_W-1:0] run_a [9];
    logic [PIX_W-1:0] run_b [9];
    root_plan = '{4'd2, 4'd15, 4'd0, 4'd8, 4'd1, 4'd9, 4'd3, 4'd5, 4'd7};
    root_plan[8] = 4'($urandom_range(0, 15));
    run_a = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F};
    run_b = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h00, 8'h01, 8'h02, 8'h03, 8'hFC};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: single-pixel images and repeated strings at the reset width, then the
    // narrowest width with bits above it set.
    send_pixel(8'hFF, 1'b1);
    foreach (run_a[i]) send_pixel(run_a[i], i == 8);
    settle();
    write_root(4'd2);
    send_pixel(8'hFF, 1'b1);
    foreach (run_b[i]) send_pixel(run_b[i], i == 8);

    // Random images under three idling regimes and a range of widths.
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 27 : (mode == 1) ? 78 : 0;
      recv_idle_pct = (mode == 0) ? 78 : (mode == 1) ? 27 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        settle();
        write_root(root_plan[mode * 3 + seg]);
        random_images(28);
      end
    end

    // Drain and let any late word show up.
    pixel_valid <= 1'b0;
    while (sb.due_bytes.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Sent %0d pixel words in %0d images with %0d table-full restarts; %0d bytes checked.",
             sb.pixels, sb.images, sb.restarts, sb.bytes_seen);
    $display("Root widths covered both clamps; idling ran sender-heavy, receiver-heavy and off.");
    if (sb.errors == 0 && sb.due_bytes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
